@@ hdl/u8wt_pkg.sv @@
package u8wt_pkg;

	// target encoding codes
	localparam logic [2:0] ENC_UTF16LE = 3'd0;
	localparam logic [2:0] ENC_UTF16BE = 3'd1;
	localparam logic [2:0] ENC_UTF32LE = 3'd2;
	localparam logic [2:0] ENC_UTF32BE = 3'd3;
	localparam logic [2:0] ENC_ASCII   = 3'd4;
	localparam logic [2:0] ENC_LATIN1  = 3'd5;

	// result kinds
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_ERR  = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	localparam int CP_W = 21;

	localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
	localparam logic [CP_W-1:0] CP_SUPP    = 21'h010000;
	localparam logic [CP_W-1:0] CP_ASCII   = 21'h000080;
	localparam logic [CP_W-1:0] CP_LATIN1  = 21'h000100;
	localparam logic [9:0]      SURR_TOP   = 10'h01B;
	localparam logic [5:0]      HI_SURR    = 6'b110110;
	localparam logic [5:0]      LO_SURR    = 6'b110111;

	// group of up to four result words from one input word
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      cnt_m1;
		logic [1:0]      kind;
	} grp_t;

endpackage

@@ hdl/u8wt_decode.sv @@
module u8wt_decode
	import u8wt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_wr_data,
	input  logic       in_acc,
	input  logic [7:0] in_byte,
	input  logic       is_end,
	input  logic       grp_take,
	output logic       grp_valid_s1,
	output grp_t       grp_s1
);

	logic [2:0]      enc_q;
	logic [CP_W-1:0] cp_q;
	logic [1:0]      pend_q;
	logic            hold_q;

	logic [CP_W-1:0] cp_d;
	logic [1:0]      pend_d;
	logic            hold_d;
	logic            has_res;
	grp_t            grp_d;

	always_comb begin
		logic [CP_W-1:0] u;
		logic [CP_W-1:0] cp_sh;
		logic [19:0]     v;
		logic [15:0]     w0;
		logic [15:0]     w1;
		logic            do_emit;
		logic            do_fail;
		cp_d    = cp_q;
		pend_d  = pend_q;
		hold_d  = hold_q;
		has_res = 1'b0;
		grp_d   = '0;
		u       = '0;
		v       = '0;
		w0      = '0;
		w1      = '0;
		do_emit = 1'b0;
		do_fail = 1'b0;
		cp_sh   = {cp_q[CP_W-7:0], in_byte[5:0]};
		if (is_end) begin
			cp_d         = '0;
			pend_d       = '0;
			hold_d       = 1'b0;
			has_res      = 1'b1;
			grp_d.kind   = KIND_END;
			grp_d.cnt_m1 = 2'd0;
		end else if (!hold_q) begin
			if (pend_q == 2'd0) begin
				if (!in_byte[7]) begin
					u       = {13'd0, in_byte};
					do_emit = 1'b1;
				end else if (in_byte[7:5] == 3'b110) begin
					cp_d   = {16'd0, in_byte[4:0]};
					pend_d = 2'd1;
				end else if (in_byte[7:4] == 4'b1110) begin
					cp_d   = {17'd0, in_byte[3:0]};
					pend_d = 2'd2;
				end else if (in_byte[7:3] == 5'b11110) begin
					cp_d   = {18'd0, in_byte[2:0]};
					pend_d = 2'd3;
				end else begin
					do_fail = 1'b1;
				end
			end else if (in_byte[7:6] != 2'b10) begin
				do_fail = 1'b1;
			end else begin
				cp_d   = cp_sh;
				pend_d = pend_q - 2'd1;
				if (pend_q == 2'd1) begin
					u       = cp_sh;
					do_emit = 1'b1;
				end
			end
		end

		if (do_emit) begin
			cp_d    = '0;
			has_res = 1'b1;
			v       = 20'(u - CP_SUPP);
			w0      = u[15:0];
			w1      = {LO_SURR, v[9:0]};
			if (u >= CP_SUPP) begin
				w0 = {HI_SURR, v[19:10]};
			end
			if (u > CP_MAX || u[CP_W-1:11] == SURR_TOP) begin
				do_fail = 1'b1;
			end else begin
				grp_d.kind = KIND_DATA;
				case (enc_q)
					ENC_UTF16LE: begin
						grp_d.bytes  = {w1[15:8], w1[7:0], w0[15:8], w0[7:0]};
						grp_d.cnt_m1 = (u >= CP_SUPP) ? 2'd3 : 2'd1;
					end
					ENC_UTF16BE: begin
						grp_d.bytes  = {w1[7:0], w1[15:8], w0[7:0], w0[15:8]};
						grp_d.cnt_m1 = (u >= CP_SUPP) ? 2'd3 : 2'd1;
					end
					ENC_UTF32LE: begin
						grp_d.bytes  = {8'd0, 3'd0, u[20:16], u[15:8], u[7:0]};
						grp_d.cnt_m1 = 2'd3;
					end
					ENC_UTF32BE: begin
						grp_d.bytes  = {u[7:0], u[15:8], 3'd0, u[20:16], 8'd0};
						grp_d.cnt_m1 = 2'd3;
					end
					ENC_ASCII: begin
						grp_d.bytes  = {24'd0, u[7:0]};
						grp_d.cnt_m1 = 2'd0;
						do_fail      = (u >= CP_ASCII);
					end
					ENC_LATIN1: begin
						grp_d.bytes  = {24'd0, u[7:0]};
						grp_d.cnt_m1 = 2'd0;
						do_fail      = (u >= CP_LATIN1);
					end
					default: begin
						do_fail = 1'b1;
					end
				endcase
			end
		end

		if (do_fail) begin
			cp_d         = '0;
			pend_d       = '0;
			hold_d       = 1'b1;
			has_res      = 1'b1;
			grp_d        = '0;
			grp_d.kind   = KIND_ERR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_q        <= ENC_UTF16LE;
			cp_q         <= '0;
			pend_q       <= '0;
			hold_q       <= 1'b0;
			grp_valid_s1 <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				enc_q <= cfg_wr_data;
			end
			if (in_acc) begin
				cp_q         <= cp_d;
				pend_q       <= pend_d;
				hold_q       <= hold_d;
				grp_valid_s1 <= has_res;
			end else if (grp_take) begin
				grp_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && has_res) begin
			grp_s1 <= grp_d;
		end
	end

endmodule

@@ hdl/u8wt_serialize.sv @@
module u8wt_serialize
	import u8wt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       grp_valid_s1,
	input  grp_t       grp_s1,
	output logic       ser_take,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [1:0] kind,
	output logic       last
);

	logic       ser_valid_q;
	grp_t       ser_q;
	logic [1:0] idx_q;

	assign out_valid = ser_valid_q;
	assign out_byte  = ser_q.bytes[idx_q];
	assign kind      = ser_q.kind;
	assign last      = (idx_q == ser_q.cnt_m1);
	// free once the final word of the group goes out
	assign ser_take  = !ser_valid_q || (!out_stall && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (ser_take) begin
			ser_valid_q <= grp_valid_s1;
			idx_q       <= '0;
		end else if (!out_stall) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ser_take && grp_valid_s1) begin
			ser_q <= grp_s1;
		end
	end

endmodule

@@ hdl/utf8_to_wide_text_encoder_unit.sv @@
// utf-8 to utf-16/utf-32/ascii/latin-1 transcoder
// input channel: in_valid/in_stall with in_byte and is_end, one utf-8 byte
//   per word; is_end closes the stream and clears the decoder
// output channel: out_valid/out_stall with out_byte, kind, last; one byte
//   per word, last marks the final word caused by an input word
// config: cfg_wr_en/cfg_wr_data write target_encoding; write only while idle, the block does not enforce it
// path: an accepted input word goes into the group register, then into the
//   serializer register; its first output word shows when the output side is free
// throughput: one output word per cycle from the serializer while out_stall
//   is low; an input word makes 1 to 4 output words, a lead or held byte
//   makes none; the group register lets the next input word be taken while
//   the serializer is still sending
// errors give one kind=error word, then bytes are dropped until is_end
// reset: decoder state clears, target encoding returns to utf16le, both
//   output registers empty
// output stall: the serializer holds its word, the group register fills,
//   then in_stall rises
module utf8_to_wide_text_encoder_unit
	import u8wt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       is_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [1:0] kind,
	output logic       last
);

	logic grp_valid_s1;
	grp_t grp_s1;
	logic ser_take;
	logic grp_take;
	logic in_acc;

	// group register moves on whenever the serializer frees up
	assign grp_take = grp_valid_s1 && ser_take;
	assign in_stall = grp_valid_s1 && !ser_take;
	assign in_acc   = in_valid && !in_stall;

	u8wt_decode u_dec (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_acc       (in_acc),
		.in_byte      (in_byte),
		.is_end       (is_end),
		.grp_take     (grp_take),
		.grp_valid_s1 (grp_valid_s1),
		.grp_s1       (grp_s1)
	);

	u8wt_serialize u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.grp_valid_s1 (grp_valid_s1),
		.grp_s1       (grp_s1),
		.ser_take     (ser_take),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.kind         (kind),
		.last         (last)
	);

endmodule

@@ hdl/u8wt_check.sv @@
module u8wt_check
	import u8wt_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic [1:0] kind,
	input logic       last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(kind)
			&& $stable(last))
		else $error("stalled output word changed");

	a_kind_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind == KIND_DATA || kind == KIND_ERR || kind == KIND_END)
		else $error("bad result kind");

	a_ctrl_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_DATA |-> last && out_byte == 8'd0)
		else $error("error or end word not single and zero");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

endmodule

bind utf8_to_wide_text_encoder_unit u8wt_check u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_byte  (out_byte),
	.kind      (kind),
	.last      (last)
);
